/* hw/rtl/rmv_pkg.sv */
// ----------------------------------------------------------------------------
// rmv_pkg
// Shared types and constants for the running mean, variance and min/max unit.
// ----------------------------------------------------------------------------
package rmv_pkg;

  // Default field geometry of a sample.
  localparam int unsigned SampleWidthDef = 32;
  localparam int unsigned FracBitsDef    = 16;

  // Fixed widths of the ports and of the statistics registers.
  localparam int unsigned SamplePortW = 32;
  localparam int unsigned CountW      = 32;
  localparam int unsigned TotalW      = 64;
  localparam int unsigned SqDevW      = 64;
  localparam int unsigned StatW       = 32;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MEAN,
    ST_D2,
    ST_PROD,
    ST_ACC,
    ST_WRITE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_clear;
    logic accept_record;
    logic div_step;
    logic mean_upd;
    logic d2_calc;
    logic prod_calc;
    logic acc_upd;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage

/* hw/rtl/running_mean_variance_minmax_unit.sv */
// ----------------------------------------------------------------------------
// running_mean_variance_minmax_unit
// Running count, saturating sum, mean, sum of squared deviations, minimum and
// maximum over signed fixed-point samples, updated one item at a time.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+------------------------------
//   in      | input     | in_valid_i/in_ready_o | kind_i, sample_i
//   out     | output    | out_valid_o/out_ready_i | sample_count_o, sum_total_o,
//           |           |                       | mean_o, sq_dev_sum_o,
//           |           |                       | minimum_o, maximum_o
//
// A sample item occupies the unit from acceptance through SAMPLE_WIDTH steps of
// the one-bit restoring divider that forms delta / count, then mean, second
// delta, multiply, accumulate and output load. A clear item goes from
// acceptance straight to the output load.
// Reset returns all statistics to their cleared values and empties the output.
// in_ready_o is high whenever the sequencer is idle, even while a result waits
// in the output register; a new result waits in the last step until the
// previous one has been taken.
//
module running_mean_variance_minmax_unit import rmv_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef,
  parameter int unsigned FRAC_BITS    = FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic signed [SamplePortW-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [CountW-1:0]             sample_count_o,
  output logic signed [TotalW-1:0]      sum_total_o,
  output logic signed [StatW-1:0]       mean_o,
  output logic [SqDevW-1:0]             sq_dev_sum_o,
  output logic signed [StatW-1:0]       minimum_o,
  output logic signed [StatW-1:0]       maximum_o
);

  // Commands flow from the sequencer to the datapath; the datapath reports
  // back only when the divider is on its last step.
  cmd_t cmd;
  sts_t sts;

  rmv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath holds the statistics themselves and the output register, so
  // a finished result stays put while the next item is being worked on.
  rmv_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_i       (sample_i),
    .sample_count_o (sample_count_o),
    .sum_total_o    (sum_total_o),
    .mean_o         (mean_o),
    .sq_dev_sum_o   (sq_dev_sum_o),
    .minimum_o      (minimum_o),
    .maximum_o      (maximum_o)
  );

endmodule

/* hw/rtl/rmv_ctrl.sv */
// ----------------------------------------------------------------------------
// rmv_ctrl
// Sequencer for one item: accept, serial divide, mean, square term, output.
// ----------------------------------------------------------------------------
module rmv_ctrl import rmv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic kind_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   load;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign load   = (state_q == ST_WRITE) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = kind_i ? ST_WRITE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = ST_MEAN;
        end
      end
      ST_MEAN:  state_d = ST_D2;
      ST_D2:    state_d = ST_PROD;
      ST_PROD:  state_d = ST_ACC;
      ST_ACC:   state_d = ST_WRITE;
      ST_WRITE: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o               = '0;
    cmd_o.accept_clear  = accept && kind_i;
    cmd_o.accept_record = accept && !kind_i;
    cmd_o.div_step      = (state_q == ST_DIV);
    cmd_o.mean_upd      = (state_q == ST_MEAN);
    cmd_o.d2_calc       = (state_q == ST_D2);
    cmd_o.prod_calc     = (state_q == ST_PROD);
    cmd_o.acc_upd       = (state_q == ST_ACC);
    cmd_o.load_out      = load;
    in_ready_o          = (state_q == ST_IDLE);
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hw/rtl/rmv_datapath.sv */
// ----------------------------------------------------------------------------
// rmv_datapath
// Statistics registers, restoring divider, squared-deviation multiplier and
// output registers.
// ----------------------------------------------------------------------------
module rmv_datapath import rmv_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef,
  parameter int unsigned FRAC_BITS    = FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic signed [SamplePortW-1:0] sample_i,
  output logic [CountW-1:0]        sample_count_o,
  output logic signed [TotalW-1:0] sum_total_o,
  output logic signed [StatW-1:0]  mean_o,
  output logic [SqDevW-1:0]        sq_dev_sum_o,
  output logic signed [StatW-1:0]  minimum_o,
  output logic signed [StatW-1:0]  maximum_o
);

  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned CntW = $clog2(SW);
  localparam logic signed [SW-1:0] SmpMax = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SmpMin = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [TotalW-1:0] TotMax = {1'b0, {(TotalW-1){1'b1}}};
  localparam logic signed [TotalW-1:0] TotMin = {1'b1, {(TotalW-1){1'b0}}};

  // Architectural statistics.
  logic [CountW-1:0]        count_q;
  logic signed [TotalW-1:0] total_q;
  logic signed [SW-1:0]     mean_q;
  logic [SqDevW-1:0]        sqdev_q;
  logic signed [SW-1:0]     min_q;
  logic signed [SW-1:0]     max_q;

  // Working registers for one item.
  logic signed [SW-1:0] smp_q;
  logic                 neg_q;
  logic [SW-1:0]        mag1_q;
  logic [SW-1:0]        mag2_q;
  logic [SW-1:0]        dq_q;
  logic [CountW-1:0]    rem_q;
  logic [CntW-1:0]      cnt_q;
  logic [2*SW-1:0]      prod_q;

  logic signed [SW-1:0]     smp_in;
  logic signed [SW:0]       d1;
  logic signed [SW:0]       d2;
  logic signed [SW:0]       d1_neg;
  logic signed [SW:0]       d2_neg;
  logic signed [TotalW-1:0] smp_ext;
  logic signed [TotalW-1:0] tot_sum;
  logic signed [TotalW-1:0] tot_sat;
  logic [CountW:0]          div_shift;
  logic [CountW:0]          div_den;
  logic                     div_ge;
  logic [CountW:0]          div_diff;
  logic signed [SW:0]       q_signed;
  logic signed [SW:0]       mean_sum;
  logic [SqDevW-1:0]        sq_inc;
  logic [SqDevW:0]          sq_sum;

  assign smp_in  = sample_i[SW-1:0];
  assign d1      = (SW+1)'(smp_in) - (SW+1)'(mean_q);
  assign d1_neg  = -d1;
  assign d2      = (SW+1)'(smp_q) - (SW+1)'(mean_q);
  assign d2_neg  = -d2;

  assign smp_ext = TotalW'(smp_in);
  assign tot_sum = total_q + smp_ext;
  always_comb begin
    if ((total_q[TotalW-1] == smp_ext[TotalW-1]) &&
        (tot_sum[TotalW-1] != smp_ext[TotalW-1])) begin
      tot_sat = smp_ext[TotalW-1] ? TotMin : TotMax;
    end else begin
      tot_sat = tot_sum;
    end
  end

  // One restoring step per cycle: the quotient shifts into dq_q.
  assign div_shift = {rem_q, dq_q[SW-1]};
  assign div_den   = {1'b0, count_q};
  assign div_ge    = (div_shift >= div_den);
  assign div_diff  = div_shift - div_den;

  assign q_signed  = neg_q ? -{1'b0, dq_q} : {1'b0, dq_q};
  assign mean_sum  = (SW+1)'(mean_q) + q_signed;

  assign sq_inc    = SqDevW'(prod_q >> FRAC_BITS);
  assign sq_sum    = {1'b0, sqdev_q} + {1'b0, sq_inc};

  assign sts_o.div_last = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      mean_q  <= '0;
      sqdev_q <= '0;
      min_q   <= SmpMax;
      max_q   <= SmpMin;
    end else begin
      if (cmd_i.accept_clear) begin
        count_q <= '0;
        total_q <= '0;
        mean_q  <= '0;
        sqdev_q <= '0;
        min_q   <= SmpMax;
        max_q   <= SmpMin;
      end else if (cmd_i.accept_record) begin
        if (count_q != '1) begin
          count_q <= count_q + CountW'(1);
        end
        total_q <= tot_sat;
        if (smp_in < min_q) begin
          min_q <= smp_in;
        end
        if (smp_in > max_q) begin
          max_q <= smp_in;
        end
      end
      if (cmd_i.mean_upd) begin
        mean_q <= mean_sum[SW-1:0];
      end
      if (cmd_i.acc_upd) begin
        sqdev_q <= sq_sum[SqDevW] ? '1 : sq_sum[SqDevW-1:0];
      end
    end
  end

  // Working registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_record) begin
      smp_q  <= smp_in;
      neg_q  <= d1[SW];
      mag1_q <= d1[SW] ? d1_neg[SW-1:0] : d1[SW-1:0];
      dq_q   <= d1[SW] ? d1_neg[SW-1:0] : d1[SW-1:0];
      rem_q  <= '0;
      cnt_q  <= CntW'(SW - 1);
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? div_diff[CountW-1:0] : div_shift[CountW-1:0];
      dq_q  <= {dq_q[SW-2:0], div_ge};
      cnt_q <= cnt_q - CntW'(1);
    end
    if (cmd_i.d2_calc) begin
      mag2_q <= d2[SW] ? d2_neg[SW-1:0] : d2[SW-1:0];
    end
    if (cmd_i.prod_calc) begin
      prod_q <= (2*SW)'(mag1_q) * (2*SW)'(mag2_q);
    end
    if (cmd_i.load_out) begin
      sample_count_o <= count_q;
      sum_total_o    <= total_q;
      mean_o         <= StatW'(mean_q);
      sq_dev_sum_o   <= sqdev_q;
      minimum_o      <= StatW'(min_q);
      maximum_o      <= StatW'(max_q);
    end
  end

endmodule

/* hw/rtl/rmv_checker.sv */
// ----------------------------------------------------------------------------
// rmv_checker
// Port-level checks for the running statistics unit, bound to the top level.
// ----------------------------------------------------------------------------
module rmv_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [31:0]        sample_count_o,
  input logic signed [63:0] sum_total_o,
  input logic signed [31:0] mean_o,
  input logic [63:0]        sq_dev_sum_o,
  input logic signed [31:0] minimum_o,
  input logic signed [31:0] maximum_o
);

  // A result that is not taken holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_count_o) &&
      $stable(sum_total_o) && $stable(mean_o) && $stable(sq_dev_sum_o) &&
      $stable(minimum_o) && $stable(maximum_o))
    else $error("result changed while stalled");

  // The unit works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // Whenever the count is nonzero, the mean must lie between the smallest and largest sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sample_count_o != 32'd0) |->
      (minimum_o <= mean_o) && (mean_o <= maximum_o))
    else $error("mean outside min/max");

  // With no samples, the accumulated statistics are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sample_count_o == 32'd0) |->
      (sum_total_o == 64'sd0) && (mean_o == 32'sd0) && (sq_dev_sum_o == 64'd0))
    else $error("nonzero statistics with zero count");

endmodule

bind running_mean_variance_minmax_unit rmv_checker u_rmv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .sample_count_o (sample_count_o),
  .sum_total_o    (sum_total_o),
  .mean_o         (mean_o),
  .sq_dev_sum_o   (sq_dev_sum_o),
  .minimum_o      (minimum_o),
  .maximum_o      (maximum_o)
);
